// ----- rtl/core/bezier_point_evaluator_assert.svh -----
// ----------------------------------------------------------------------------
// Bezier point evaluator assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BEZIER_POINT_EVALUATOR_ASSERT_SVH
`define BEZIER_POINT_EVALUATOR_ASSERT_SVH

// Same-cycle implication.
`define BPE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BPE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/bpe_pkg.sv -----
// ----------------------------------------------------------------------------
// bpe_pkg
// Types and fixed widths shared by the Bezier point evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpe_pkg;

  localparam int unsigned CoordW = 24;  // signed Q15.8
  localparam int unsigned ParamW = 18;  // signed Q1.16
  localparam int unsigned TW     = 17;  // clamped t, 0..65536
  localparam int unsigned FracW  = 16;
  localparam int unsigned CountW = 5;
  localparam int unsigned IndexW = 4;

  localparam logic [TW-1:0]     TOne       = 17'h10000;
  localparam logic [CountW-1:0] CountReset = 5'd1;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } bpe_op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } bpe_state_e;

  typedef struct packed {
    logic wr_point;  // write the beat's point into the store
    logic start;     // copy store to work row, latch clamped t
    logic step;      // reduce one de Casteljau level
    logic load_out;  // move work[0] into the result register
  } bpe_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/bpe_if.sv -----
// ----------------------------------------------------------------------------
// bpe channel interfaces
// Valid/ready channels for configuration, input items and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpe_cfg_if;
  import bpe_pkg::*;
  logic              valid;
  logic              ready;
  logic [CountW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bpe_in_if;
  import bpe_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [IndexW-1:0]        point_index;
  logic signed [CoordW-1:0] point_x;
  logic signed [CoordW-1:0] point_y;
  logic signed [ParamW-1:0] curve_param;

  modport source (output valid, output op, output point_index, output point_x,
                  output point_y, output curve_param, input ready);
  modport sink   (input valid, input op, input point_index, input point_x,
                  input point_y, input curve_param, output ready);
endinterface

interface bpe_out_if;
  import bpe_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] curve_x;
  logic signed [CoordW-1:0] curve_y;

  modport source (output valid, output curve_x, output curve_y, input ready);
  modport sink   (input valid, input curve_x, input curve_y, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bpe_lerp.sv -----
// ----------------------------------------------------------------------------
// bpe_lerp
// One interpolation cell: a + floor((b - a) * t / 2^16).
// ----------------------------------------------------------------------------
`default_nettype none

module bpe_lerp (
  input  logic signed [bpe_pkg::CoordW-1:0] a_i,
  input  logic signed [bpe_pkg::CoordW-1:0] b_i,
  input  logic        [bpe_pkg::TW-1:0]     t_i,
  output logic signed [bpe_pkg::CoordW-1:0] y_o
);
  import bpe_pkg::*;

  localparam int unsigned DiffW = CoordW + 1;
  localparam int unsigned ProdW = DiffW + TW + 1;

  logic signed [DiffW-1:0] diff;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] scaled;

  assign diff   = $signed({b_i[CoordW-1], b_i}) - $signed({a_i[CoordW-1], a_i});
  assign prod   = diff * $signed({1'b0, t_i});
  // Arithmetic shift floors negative products.
  assign scaled = prod >>> FracW;
  // Result lies between a and b, so wrapping to 24 bits is exact.
  assign y_o    = a_i + scaled[CoordW-1:0];

endmodule

`default_nettype wire

// ----- rtl/core/bpe_ctrl.sv -----
// ----------------------------------------------------------------------------
// bpe_ctrl
// Sequencer: accepts beats, counts reduction levels, owns result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module bpe_ctrl #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [bpe_pkg::CountW-1:0]   cfg_data_i,
  output logic                         cfg_ready_o,
  input  logic                         in_valid_i,
  input  logic                         in_op_i,
  output logic                         in_ready_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output bpe_pkg::bpe_cmd_t            cmd_o
);
  import bpe_pkg::*;

  localparam int unsigned LvlW = $clog2(MAX_POINTS);

  bpe_state_e        state_q, state_d;
  logic [LvlW-1:0]   lvl_q, lvl_d;
  logic              out_valid_q, out_valid_d;
  logic [CountW-1:0] count_q;
  logic [LvlW-1:0]   levels;
  logic              in_acc;
  logic              out_free;

  // Levels to run: clamped point count minus one.
  always_comb begin
    priority if (count_q == '0) begin
      levels = '0;
    end else if (32'(count_q) > MAX_POINTS) begin
      levels = LvlW'(MAX_POINTS - 1);
    end else begin
      levels = LvlW'(count_q - CountW'(1));
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    lvl_d       = lvl_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_op_i == OP_EVAL) begin
            cmd_o.start = 1'b1;
            lvl_d       = levels;
            state_d     = ST_RUN;
          end else begin
            cmd_o.wr_point = 1'b1;
          end
        end
      end
      ST_RUN: begin
        if (lvl_q != '0) begin
          cmd_o.step = 1'b1;
          lvl_d      = lvl_q - LvlW'(1);
        end else if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lvl_q       <= '0;
      out_valid_q <= 1'b0;
      count_q     <= CountReset;
    end else begin
      state_q     <= state_d;
      lvl_q       <= lvl_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/bpe_datapath.sv -----
// ----------------------------------------------------------------------------
// bpe_datapath
// Point store, work row with its interpolation cells, and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpe_datapath #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic                             clk_i,
  input  bpe_pkg::bpe_cmd_t                cmd_i,
  input  logic [bpe_pkg::IndexW-1:0]       point_index_i,
  input  logic signed [bpe_pkg::CoordW-1:0] point_x_i,
  input  logic signed [bpe_pkg::CoordW-1:0] point_y_i,
  input  logic signed [bpe_pkg::ParamW-1:0] curve_param_i,
  output logic signed [bpe_pkg::CoordW-1:0] curve_x_o,
  output logic signed [bpe_pkg::CoordW-1:0] curve_y_o
);
  import bpe_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_POINTS);

  logic signed [CoordW-1:0] store_x_q [MAX_POINTS];
  logic signed [CoordW-1:0] store_y_q [MAX_POINTS];
  logic signed [CoordW-1:0] work_x_q  [MAX_POINTS];
  logic signed [CoordW-1:0] work_y_q  [MAX_POINTS];
  logic signed [CoordW-1:0] lerp_x    [MAX_POINTS-1];
  logic signed [CoordW-1:0] lerp_y    [MAX_POINTS-1];
  logic [TW-1:0]            t_q, t_clamp;
  logic signed [CoordW-1:0] curve_x_q, curve_y_q;
  logic                     idx_ok;
  logic [IdxW-1:0]          idx;

  assign idx_ok = 32'(point_index_i) < MAX_POINTS;
  assign idx    = IdxW'(point_index_i);

  // Clamp t to 0..1.
  always_comb begin
    priority if (curve_param_i[ParamW-1]) begin
      t_clamp = '0;
    end else if (curve_param_i[ParamW-2:0] > TOne) begin
      t_clamp = TOne;
    end else begin
      t_clamp = curve_param_i[TW-1:0];
    end
  end

  for (genvar i = 0; i < MAX_POINTS - 1; i++) begin : g_cell
    bpe_lerp u_lerp_x (
      .a_i (work_x_q[i]),
      .b_i (work_x_q[i+1]),
      .t_i (t_q),
      .y_o (lerp_x[i])
    );
    bpe_lerp u_lerp_y (
      .a_i (work_y_q[i]),
      .b_i (work_y_q[i+1]),
      .t_i (t_q),
      .y_o (lerp_y[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_point && idx_ok) begin
      store_x_q[idx] <= point_x_i;
      store_y_q[idx] <= point_y_i;
    end
  end

  // Cells past the live count compute junk that never reaches entry zero.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      t_q <= t_clamp;
      for (int i = 0; i < MAX_POINTS; i++) begin
        work_x_q[i] <= store_x_q[i];
        work_y_q[i] <= store_y_q[i];
      end
    end else if (cmd_i.step) begin
      for (int i = 0; i < MAX_POINTS - 1; i++) begin
        work_x_q[i] <= lerp_x[i];
        work_y_q[i] <= lerp_y[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      curve_x_q <= work_x_q[0];
      curve_y_q <= work_y_q[0];
    end
  end

  assign curve_x_o = curve_x_q;
  assign curve_y_o = curve_y_q;

endmodule

`default_nettype wire

// ----- rtl/core/bezier_point_evaluator.sv -----
// ----------------------------------------------------------------------------
// bezier_point_evaluator
// De Casteljau evaluation of a 2D Bezier curve over a small control point store.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_ch : one write beat sets point_count (points used per evaluation).
//            Always ready. Write only while the block is idle.
//   in_ch  : op = load writes (point_x, point_y) into slot point_index;
//            slots at or above MAX_POINTS are dropped. op = eval evaluates
//            the curve at curve_param (Q1.16, clamped to 0..1).
//   out_ch : one result beat (curve_x, curve_y) per evaluate beat.
// Sequence:
//   Loads can stream back to back.
//   An evaluate with n points in use (n = point_count clamped to 1..MAX_POINTS)
//   copies the store into the work row at the accept edge, then the row of
//   interpolation cells reduces one level per cycle through n - 1 levels, then
//   the result register is loaded and out valid rises. The input is not
//   ready during that time, so a new item waits until the evaluate has run
//   its level loop through the single cell row and loaded its result.
// Stall: the result register holds while out ready is low; the next item is
//   still accepted, and a following evaluate waits at its last level until
//   the register frees up.
// Reset: point_count returns to 1, channels go idle; the store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module bezier_point_evaluator #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bpe_cfg_if.sink   cfg_ch,
  bpe_in_if.sink    in_ch,
  bpe_out_if.source out_ch
);
  import bpe_pkg::*;

  bpe_cmd_t cmd;

  // Sequencer: handshakes, level count, result valid.
  bpe_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_ch.valid),
    .cfg_data_i  (cfg_ch.data),
    .cfg_ready_o (cfg_ch.ready),
    .in_valid_i  (in_ch.valid),
    .in_op_i     (in_ch.op),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .cmd_o       (cmd)
  );

  // Store, work row of cells, result register.
  bpe_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .point_index_i (in_ch.point_index),
    .point_x_i     (in_ch.point_x),
    .point_y_i     (in_ch.point_y),
    .curve_param_i (in_ch.curve_param),
    .curve_x_o     (out_ch.curve_x),
    .curve_y_o     (out_ch.curve_y)
  );

endmodule

`default_nettype wire

// ----- rtl/core/bpe_checker.sv -----
// ----------------------------------------------------------------------------
// bpe_checker
// Port-level checks on the Bezier point evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bezier_point_evaluator_assert.svh"

module bpe_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             in_op_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic signed [bpe_pkg::CoordW-1:0] curve_x_i,
  input logic signed [bpe_pkg::CoordW-1:0] curve_y_i
);
  import bpe_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // A stalled result holds.
  `BPE_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(curve_x_i) && $stable(curve_y_i), "stalled result changed")
  // An evaluate blocks the input once it is accepted.
  `BPE_ASSERT_NXT(a_eval_busy, in_acc && (in_op_i == OP_EVAL), !in_ready_i, "input ready after evaluate")
  // A load never blocks the input.
  `BPE_ASSERT_NXT(a_load_free, in_acc && (in_op_i == OP_LOAD), in_ready_i, "input blocked after load")
  // A new result only appears at the end of an evaluation.
  `BPE_ASSERT_IMP(a_out_origin, $rose(out_valid_i), !$past(in_ready_i), "result without evaluation")

endmodule

bind bezier_point_evaluator bpe_checker u_bpe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .in_op_i     (in_ch.op),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .curve_x_i   (out_ch.curve_x),
  .curve_y_i   (out_ch.curve_y)
);

`default_nettype wire
